>>> rtl/par_pkg.sv
// ----------------------------------------------------------------------------
// par_pkg
// Shared types and constants of the Pareto archive update block.
// ----------------------------------------------------------------------------
`default_nettype none

package par_pkg;

	localparam int CAPACITY  = 64;
	localparam int NUM_OBJ   = 4;
	localparam int OBJ_WIDTH = 32;
	localparam int TAG_W     = 16;
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int CFG_W     = 3;

	localparam logic [CFG_W-1:0] K_RESET = CFG_W'(NUM_OBJ);

	localparam int IN_BITS  = NUM_OBJ * OBJ_WIDTH + TAG_W + IDX_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int RES_BITS = 3 + 2 * CNT_W + NUM_OBJ * OBJ_WIDTH + TAG_W;
	localparam int OUT_W    = ((RES_BITS + 7) / 8) * 8;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ   = 1'b1;

	typedef logic signed [OBJ_WIDTH-1:0] obj_t;
	typedef obj_t [NUM_OBJ-1:0] obj_vec_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		obj_vec_t         obj;
	} entry_t;

	typedef struct packed {
		logic [IN_W-IN_BITS-1:0] pad;
		logic [IDX_W-1:0]        read_index;
		logic [TAG_W-1:0]        sol_tag;
		obj_vec_t                obj;
	} in_t;

	typedef struct packed {
		logic [OUT_W-RES_BITS-1:0] pad;
		logic [TAG_W-1:0]          read_tag;
		obj_vec_t                  read_obj;
		logic                      read_valid;
		logic [CNT_W-1:0]          front_count;
		logic [CNT_W-1:0]          removed_count;
		logic                      overflow;
		logic                      accepted;
	} res_t;

	typedef struct packed {
		logic ent_dom;
		logic cand_dom;
	} par_dom_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH,
		ST_READ,
		ST_DONE
	} par_state_t;

endpackage

`default_nettype wire

>>> rtl/pareto_archive_update.sv
// ----------------------------------------------------------------------------
// pareto_archive_update
// Ordered archive of mutually non-dominated solutions (maximization).
// ----------------------------------------------------------------------------
//  channel  | direction | request contents
//  s_*      | in        | tuser: op; tdata: obj_0..obj_3, sol_tag, read_index
//  m_*      | out       | tdata: accepted, overflow, removed_count, front_count,
//           |           |        read_valid, read_obj_0..read_obj_3, read_tag
//  cfg_*    | in        | cfg_data: active_objectives
//
//  an insert walks the whole archive between accept and result: the walk
//  reads one archive entry per cycle from a single RAM read port and
//  runs it through the one dominance compare unit, compacting as it goes.
//  the next request is taken once the result has moved into the output
//  register; a stalled m_tready holds the block in its last state. reset
//  clears entry_count and control state; the archive RAM is never cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module pareto_archive_update (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// obj_0, obj_1, obj_2, obj_3, sol_tag, read_index, zero fill
	input  logic [par_pkg::IN_W-1:0]   s_tdata,
	// op
	input  logic                       s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// accepted, overflow, removed_count, front_count, read_valid,
	// read_obj_0, read_obj_1, read_obj_2, read_obj_3, read_tag, zero fill
	output logic [par_pkg::OUT_W-1:0]  m_tdata,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [par_pkg::CFG_W-1:0]  cfg_data
);
	import par_pkg::*;

	par_state_t       state_q, state_nx;
	logic [CFG_W-1:0] kcfg_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_q;
	logic [CNT_W-1:0] wr_q;
	logic [CNT_W-1:0] removed_q;
	logic             rejected_q;
	logic             hit_q;
	logic             vld_s1;
	logic [IDX_W-1:0] rd_s1;
	entry_t           cand_q;
	res_t             res_q;
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	in_t              in_req;
	logic             out_free;
	logic             ram_we, ram_re;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	entry_t           ram_wdata, ram_rdata;
	par_dom_t         dom;
	logic             keep;
	logic             reject_now;
	logic             append;
	logic [CNT_W-1:0] front_nx;
	res_t             res_nx;

	assign in_req    = in_t'(s_tdata);
	assign out_free  = !m_tvalid_q || m_tready;
	// objective count only changes between requests
	assign cfg_ready = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	par_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	par_dom u_dom (
		.ent (ram_rdata.obj),
		.cand(cand_q.obj),
		.k   (kcfg_q),
		.dom (dom)
	);

	// once rejected, the rest of the archive is only closed up
	assign keep       = rejected_q || !dom.cand_dom;
	assign reject_now = vld_s1 && !rejected_q && dom.ent_dom;
	assign append     = !rejected_q && (wr_q < CNT_W'(CAPACITY));
	assign front_nx   = append ? wr_q + CNT_W'(1) : wr_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_nx = (s_tuser == OP_READ) ? ST_READ : ST_WALK;
				end
			end
			ST_WALK: begin
				if (!vld_s1 && rd_q >= count_q) begin
					state_nx = ST_FINISH;
				end
			end
			ST_FINISH: state_nx = ST_DONE;
			ST_READ:   state_nx = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default:   state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = rd_q[IDX_W-1:0];
		ram_we    = 1'b0;
		ram_waddr = wr_q[IDX_W-1:0];
		ram_wdata = ram_rdata;
		unique case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				ram_raddr = in_req.read_index;
				ram_re    = s_tvalid && (s_tuser == OP_READ);
			end
			ST_WALK: begin
				ram_re = rd_q < count_q;
				// survivors move down only when something ahead was removed
				ram_we = vld_s1 && keep && (wr_q[IDX_W-1:0] != rd_s1);
			end
			ST_FINISH: begin
				ram_we    = append;
				ram_wdata = cand_q;
			end
			ST_READ, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res_nx = '0;
		if (state_q == ST_READ) begin
			res_nx.front_count = count_q;
			res_nx.read_valid  = hit_q;
			res_nx.read_obj    = hit_q ? ram_rdata.obj : '0;
			res_nx.read_tag    = hit_q ? ram_rdata.tag : '0;
		end else begin
			res_nx.accepted      = append;
			res_nx.overflow      = !rejected_q && !append;
			res_nx.removed_count = removed_q;
			res_nx.front_count   = front_nx;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			kcfg_q     <= K_RESET;
			count_q    <= '0;
			rd_q       <= '0;
			wr_q       <= '0;
			removed_q  <= '0;
			rejected_q <= 1'b0;
			vld_s1     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				kcfg_q <= cfg_data;
			end
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					rd_q       <= '0;
					wr_q       <= '0;
					removed_q  <= '0;
					rejected_q <= 1'b0;
					vld_s1     <= 1'b0;
				end
				ST_WALK: begin
					vld_s1 <= ram_re;
					if (ram_re) begin
						rd_q <= rd_q + CNT_W'(1);
					end
					if (vld_s1) begin
						if (keep) begin
							wr_q <= wr_q + CNT_W'(1);
						end else begin
							removed_q <= removed_q + CNT_W'(1);
						end
						if (reject_now) begin
							rejected_q <= 1'b1;
						end
					end
				end
				ST_FINISH: begin
					count_q <= front_nx;
				end
				ST_DONE: begin
				end
				ST_READ: begin
				end
				default: begin
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			cand_q.obj <= in_req.obj;
			cand_q.tag <= in_req.sol_tag;
			hit_q      <= {1'b0, in_req.read_index} < count_q;
		end
		if (state_q == ST_WALK && ram_re) begin
			rd_s1 <= rd_q[IDX_W-1:0];
		end
		if (state_q == ST_FINISH || state_q == ST_READ) begin
			res_q <= res_nx;
		end
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= res_q;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("archive count above capacity");

	a_write_behind_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (wr_q <= rd_q))
		else $error("compaction write pointer passed read pointer");

	a_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (rd_q <= count_q && wr_q + removed_q <= rd_q))
		else $error("walk counters inconsistent");

	a_acc_ovf_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> !(m_tdata_q[0] && m_tdata_q[1]))
		else $error("accepted and overflow both set");

	a_finish_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |=> (count_q == $past(front_nx)))
		else $error("archive count not updated at end of insert");

endmodule

`default_nettype wire

>>> rtl/par_ram.sv
// ----------------------------------------------------------------------------
// par_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module par_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/par_dom.sv
// ----------------------------------------------------------------------------
// par_dom
// Dominance compare unit: stored entry against candidate over active objectives.
// ----------------------------------------------------------------------------
`default_nettype none

module par_dom (
	input  par_pkg::obj_vec_t           ent,
	input  par_pkg::obj_vec_t           cand,
	input  logic [par_pkg::CFG_W-1:0]   k,
	output par_pkg::par_dom_t           dom
);
	import par_pkg::*;

	logic [CFG_W-1:0]   keff;
	logic [NUM_OBJ-1:0] gt;
	logic [NUM_OBJ-1:0] lt;

	// zero counts as one, anything above the objective count is clamped
	always_comb begin
		if (k == '0) begin
			keff = CFG_W'(1);
		end else if (k > K_RESET) begin
			keff = K_RESET;
		end else begin
			keff = k;
		end
	end

	always_comb begin
		for (int j = 0; j < NUM_OBJ; j++) begin
			gt[j] = (j < int'(keff)) && ($signed(ent[j]) > $signed(cand[j]));
			lt[j] = (j < int'(keff)) && ($signed(ent[j]) < $signed(cand[j]));
		end
		dom.ent_dom  = (|gt) && !(|lt);
		dom.cand_dom = (|lt) && !(|gt);
	end

endmodule

`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pareto_archive_update. A request queue feeds a
// clocked driver; every accepted request is run through a local archive
// predictor, and the monitor compares each result field by field. Phases
// sweep the objective count and the sender and receiver idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	import par_pkg::*;

	typedef struct packed {
		logic op;
		in_t  pl;
	} req_t;

	localparam obj_t OBJ_MAX  = 32'sh7fff_ffff;
	localparam obj_t OBJ_MIN  = 32'sh8000_0000;
	localparam obj_t OBJ_HIGH = 32'sh4000_0000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             s_tuser = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;

	pareto_archive_update dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	req_t             req_q[$];
	res_t             outcome_q[$];
	int               fail_cnt = 0;
	int               send_idle_pct = 0;
	int               recv_stall_pct = 0;

	// predicted archive contents
	obj_vec_t         front_obj[CAPACITY];
	logic [TAG_W-1:0] front_tag[CAPACITY];
	int               front_len = 0;
	logic [CFG_W-1:0] obj_k = K_RESET;

	function automatic bit roll(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// +1: a dominates b, -1: b dominates a, 0: neither
	function automatic int dom_order(obj_vec_t a, obj_vec_t b, int k);
		int better, worse;
		better = 0;
		worse = 0;
		for (int i = 0; i < k; i++) begin
			if ($signed(a[i]) > $signed(b[i]))
				better++;
			else if ($signed(a[i]) < $signed(b[i]))
				worse++;
		end
		if (better > 0 && worse == 0)
			return 1;
		if (better == 0 && worse > 0)
			return -1;
		return 0;
	endfunction

	function automatic res_t apply_request(req_t r);
		res_t o;
		int   k, keep, dropped, d;
		bit   beaten;
		o = '0;
		k = (obj_k == 0) ? 1 : (obj_k > NUM_OBJ) ? NUM_OBJ : int'(obj_k);
		if (r.op == OP_INSERT) begin
			keep = 0;
			dropped = 0;
			beaten = 1'b0;
			// once beaten, the rest of the walk only closes up
			for (int i = 0; i < front_len; i++) begin
				d = beaten ? 0 : dom_order(front_obj[i], r.pl.obj, k);
				if (d > 0)
					beaten = 1'b1;
				if (d < 0) begin
					dropped++;
				end else begin
					front_obj[keep] = front_obj[i];
					front_tag[keep] = front_tag[i];
					keep++;
				end
			end
			front_len = keep;
			if (!beaten) begin
				if (front_len >= CAPACITY) begin
					o.overflow = 1'b1;
				end else begin
					front_obj[front_len] = r.pl.obj;
					front_tag[front_len] = r.pl.sol_tag;
					front_len++;
					o.accepted = 1'b1;
				end
			end
			o.removed_count = CNT_W'(dropped);
		end else if (r.pl.read_index < front_len) begin
			o.read_valid = 1'b1;
			o.read_obj = front_obj[r.pl.read_index];
			o.read_tag = front_tag[r.pl.read_index];
		end
		o.front_count = CNT_W'(front_len);
		return o;
	endfunction

	function automatic void check_field(string name, longint unsigned want,
			longint unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_cnt++;
		end
	endfunction

	// driver: take the next request once the current one is gone
	always @(posedge clk) begin : drive
		req_t nxt;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				outcome_q = {outcome_q, apply_request({s_tuser, s_tdata})};
			if (!s_tvalid || s_tready) begin
				if (req_q.size() > 0 && !roll(send_idle_pct)) begin
					nxt = req_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= nxt.op;
					s_tdata <= nxt.pl;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : watch
		res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (outcome_q.size() == 0) begin
				$error("result with no request outstanding");
				fail_cnt++;
			end else begin
				want = outcome_q.pop_front();
				check_field("accepted", want.accepted, got.accepted);
				check_field("overflow", want.overflow, got.overflow);
				check_field("removed_count", want.removed_count, got.removed_count);
				check_field("front_count", want.front_count, got.front_count);
				check_field("read_valid", want.read_valid, got.read_valid);
				for (int i = 0; i < NUM_OBJ; i++)
					check_field($sformatf("read_obj_%0d", i), want.read_obj[i],
						got.read_obj[i]);
				check_field("read_tag", want.read_tag, got.read_tag);
			end
		end
		m_tready <= arst_n && !roll(recv_stall_pct);
	end

	function automatic obj_vec_t vec4(obj_t a, obj_t b, obj_t c, obj_t d);
		obj_vec_t v;
		v[0] = a;
		v[1] = b;
		v[2] = c;
		v[3] = d;
		return v;
	endfunction

	function automatic obj_t rand_obj();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			return $signed($urandom_range(0, 6)) - 3;
		if (pick < 55) begin
			case ($urandom_range(0, 3))
				0: return OBJ_MIN;
				1: return OBJ_MAX;
				2: return '0;
				default: return -1;
			endcase
		end
		return $urandom;
	endfunction

	task automatic push_insert(obj_vec_t v, logic [TAG_W-1:0] t);
		req_t r;
		r = '0;
		r.op = OP_INSERT;
		r.pl.obj = v;
		r.pl.sol_tag = t;
		r.pl.read_index = IDX_W'($urandom_range(0, CAPACITY - 1));
		req_q = {req_q, r};
	endtask

	task automatic push_read(logic [IDX_W-1:0] idx);
		req_t r;
		r = '0;
		r.op = OP_READ;
		r.pl.read_index = idx;
		req_q = {req_q, r};
	endtask

	task automatic plan_phase(int n_items);
		int       made, pick, n, s, j, j1, j2;
		bit       rev;
		obj_vec_t v;
		made = 0;
		while (made < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				// clear point, then a front along a diagonal, then cuts into it
				n = roll(40) ? $urandom_range(60, 72) : $urandom_range(4, 30);
				s = $urandom_range(1, 4000);
				rev = roll(30);
				push_insert(vec4(OBJ_HIGH, OBJ_HIGH, OBJ_HIGH, OBJ_HIGH),
					TAG_W'($urandom_range(0, 65535)));
				for (int jj = 0; jj < n; jj++) begin
					j = rev ? n - 1 - jj : jj;
					v = vec4(OBJ_HIGH + 1 + j * s, OBJ_HIGH + 1 + (n - j) * s,
						roll(50) ? OBJ_MAX : OBJ_HIGH + $urandom_range(0, 1000),
						roll(50) ? OBJ_MAX : OBJ_HIGH + $urandom_range(0, 1000));
					push_insert(v, TAG_W'($urandom_range(0, 65535)));
				end
				for (int c = $urandom_range(1, 3); c > 0; c--) begin
					j1 = $urandom_range(0, n - 1);
					j2 = $urandom_range(0, j1);
					push_insert(vec4(OBJ_HIGH + 1 + j1 * s, OBJ_HIGH + 1 + (n - j2) * s,
						OBJ_MAX, OBJ_MAX), TAG_W'($urandom_range(0, 65535)));
					made++;
				end
				made += n + 1;
			end else if (pick < 40) begin
				push_read(IDX_W'(roll(60) ? $urandom_range(0, 15) : $urandom_range(0, 63)));
				made++;
			end else if (pick < 70) begin
				push_insert(vec4(rand_obj(), rand_obj(), rand_obj(), rand_obj()),
					TAG_W'($urandom_range(0, 65535)));
				made++;
			end else begin
				// lands among a front: removes some entries, may be beaten later
				v = vec4(OBJ_HIGH + $urandom_range(0, 300000),
					OBJ_HIGH + $urandom_range(0, 300000),
					roll(50) ? OBJ_MAX : OBJ_HIGH + $urandom_range(0, 1000),
					roll(50) ? OBJ_MAX : rand_obj());
				push_insert(v, TAG_W'($urandom_range(0, 65535)));
				made++;
			end
		end
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (req_q.size() != 0 || s_tvalid || outcome_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_obj_count(logic [CFG_W-1:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		obj_k = v;
	endtask

	initial begin : stim
		int phase_k[10] = '{4, 0, 7, 1, 2, 3, 5, 6, 1, 2};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty read, removals, equal vectors, rejections, reads past end
		push_read(IDX_W'(0));
		push_insert(vec4(OBJ_MIN, OBJ_MIN, OBJ_MIN, OBJ_MIN), 16'h0001);
		push_insert(vec4(0, 0, 0, 0), 16'h0002);
		push_insert(vec4(0, 0, 0, 0), 16'h0003);
		push_insert(vec4(OBJ_MAX, 0, 0, 0), 16'h0000);
		push_insert(vec4(0, OBJ_MAX, OBJ_MIN, OBJ_MIN), 16'hffff);
		push_read(IDX_W'(0));
		push_read(IDX_W'(1));
		push_read(IDX_W'(2));
		push_read(IDX_W'(63));
		push_insert(vec4(OBJ_MAX, OBJ_MAX, OBJ_MAX, OBJ_MAX), 16'ha5a5);
		push_insert(vec4(OBJ_MAX, OBJ_MAX, OBJ_MAX, OBJ_MAX), 16'h5a5a);
		push_insert(vec4(OBJ_MIN, OBJ_MIN, OBJ_MIN, OBJ_MIN), 16'h1234);
		push_insert(vec4(OBJ_MAX, OBJ_MAX, OBJ_MAX, OBJ_MIN), 16'h4321);
		push_read(IDX_W'(1));
		push_read(IDX_W'(0));
		wait_drained();

		for (int p = 0; p < 10; p++) begin
			write_obj_count(CFG_W'(phase_k[p]));
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 70;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 70;
				end
				default: begin
					send_idle_pct = 27;
					recv_stall_pct = 27;
				end
			endcase
			plan_phase(72);
			wait_drained();
		end

		repeat (70) @(posedge clk);
		if (fail_cnt == 0 && outcome_q.size() == 0)
			$display("PASS pareto_archive_update");
		else
			$display("FAIL pareto_archive_update");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("FAIL pareto_archive_update");
		$finish;
	end

endmodule
